>>> src/mhi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mhi_pkg: shared types for the max-heap insert/delete unit
// Capacity, microcode encoding, the control ROM and the key compare.
// ---------------------------------------------------------------------------
package mhi_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    // microcode step addresses
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS,
        ST_UP_RD,
        ST_UP_MV,
        ST_PUT,
        ST_FIN,
        ST_DEL_START,
        ST_SCAN,
        ST_SHRINK,
        ST_MOVE,
        ST_SIFT_SEL,
        ST_DN_RD,
        ST_DN_MV
    } step_t;

    // datapath action of one step
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_INS,
        ACT_UP_RD,
        ACT_UP_MV,
        ACT_PUT,
        ACT_FIN,
        ACT_DEL_START,
        ACT_SCAN,
        ACT_SHRINK,
        ACT_MOVE,
        ACT_DN_RD,
        ACT_DN_MV
    } act_t;

    // branch condition of one step
    typedef enum logic [3:0] {
        CND_ALWAYS,
        CND_OP_DEL,
        CND_FULL,
        CND_IDX_ZERO,
        CND_UP_GT,
        CND_EMPTY,
        CND_SCAN_STOP,
        CND_DEL_END,
        CND_SIFT_UP,
        CND_NO_LEFT,
        CND_DN_GT
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t t_step;
        step_t f_step;
        logic  wait_cmd;
        logic  wait_rsp;
    } ucode_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic op_del;
        logic full;
        logic idx_zero;
        logic up_gt;
        logic empty;
        logic scan_stop;
        logic del_end;
        logic sift_up;
        logic no_left;
        logic dn_gt;
        logic cmd_valid;
        logic rsp_free;
    } flags_t;

    // control from sequencer to datapath
    typedef struct packed {
        act_t act;
        logic go;
        logic cmd_ready;
    } ctrl_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w = '{ACT_NOP, CND_ALWAYS, ST_IDLE, ST_IDLE, 1'b0, 1'b0};
        unique case (s)
            ST_IDLE:      w = '{ACT_LOAD,      CND_OP_DEL,    ST_DEL_START, ST_INS,
                                1'b1, 1'b0};
            ST_INS:       w = '{ACT_INS,       CND_FULL,      ST_FIN,       ST_UP_RD,
                                1'b0, 1'b0};
            ST_UP_RD:     w = '{ACT_UP_RD,     CND_IDX_ZERO,  ST_PUT,       ST_UP_MV,
                                1'b0, 1'b0};
            ST_UP_MV:     w = '{ACT_UP_MV,     CND_UP_GT,     ST_UP_RD,     ST_PUT,
                                1'b0, 1'b0};
            ST_PUT:       w = '{ACT_PUT,       CND_ALWAYS,    ST_FIN,       ST_FIN,
                                1'b0, 1'b0};
            ST_FIN:       w = '{ACT_FIN,       CND_ALWAYS,    ST_IDLE,      ST_IDLE,
                                1'b0, 1'b1};
            ST_DEL_START: w = '{ACT_DEL_START, CND_EMPTY,     ST_FIN,       ST_SCAN,
                                1'b0, 1'b0};
            ST_SCAN:      w = '{ACT_SCAN,      CND_SCAN_STOP, ST_SHRINK,    ST_SCAN,
                                1'b0, 1'b0};
            ST_SHRINK:    w = '{ACT_SHRINK,    CND_DEL_END,   ST_FIN,       ST_MOVE,
                                1'b0, 1'b0};
            ST_MOVE:      w = '{ACT_MOVE,      CND_ALWAYS,    ST_SIFT_SEL,  ST_SIFT_SEL,
                                1'b0, 1'b0};
            // hold the parent on the read port for the first move up
            ST_SIFT_SEL:  w = '{ACT_UP_RD,     CND_SIFT_UP,   ST_UP_MV,     ST_DN_RD,
                                1'b0, 1'b0};
            ST_DN_RD:     w = '{ACT_DN_RD,     CND_NO_LEFT,   ST_PUT,       ST_DN_MV,
                                1'b0, 1'b0};
            ST_DN_MV:     w = '{ACT_DN_MV,     CND_DN_GT,     ST_DN_RD,     ST_PUT,
                                1'b0, 1'b0};
            default:      w = '{ACT_NOP,       CND_ALWAYS,    ST_IDLE,      ST_IDLE,
                                1'b0, 1'b0};
        endcase
        return w;
    endfunction

    function automatic logic key_gt(data_t a, data_t b);
        return a > b;
    endfunction

endpackage
`default_nettype wire

>>> src/mhi_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mhi_cmd_if: command channel of the heap unit
// Valid/ready channel carrying the operation code and the value.
// ---------------------------------------------------------------------------
interface mhi_cmd_if;
    import mhi_pkg::*;

    logic  valid;
    logic  ready;
    logic  operation;
    data_t value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

>>> src/mhi_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mhi_rsp_if: result channel of the heap unit
// Valid/ready channel carrying status, element count and current maximum.
// ---------------------------------------------------------------------------
interface mhi_rsp_if;
    import mhi_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    cnt_t        element_total;
    logic        top_valid;
    data_t       top_value;

    modport source (output valid, output status, output element_total,
                    output top_valid, output top_value, input ready);
    modport sink   (input valid, input status, input element_total,
                    input top_valid, input top_value, output ready);
endinterface
`default_nettype wire

>>> src/max_heap_insert_delete_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// max_heap_insert_delete_unit: binary max-heap with insert and delete
// Microcoded datapath over a 32-entry store with one result per item.
// ---------------------------------------------------------------------------
// One item is worked at a time; a new item is taken while the previous result
// still waits on the result channel. An insert moves the value up the heap
// level by level, at most 5 levels. A delete first scans the store for the
// value, reading one entry a cycle through one of the store's read ports;
// unless the found entry is the last, it then moves the last entry into its
// place and sifts it up or down. A delete on an empty heap is reported too.
// An insert on a full heap is refused and a delete of an absent value leaves
// the heap unchanged; both are reported in the status field.
module max_heap_insert_delete_unit
    import mhi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mhi_cmd_if.sink    cmd,
    mhi_rsp_if.source  rsp
);

    ctrl_t   ctrl;
    flags_t  flags;

    data_t   heap_mem_reg [CAPACITY];
    data_t   rd_a_reg;
    data_t   rd_b_reg;
    addr_t   rd_a_addr;
    addr_t   rd_b_addr;
    logic    mem_we;
    addr_t   mem_waddr;
    data_t   mem_wdata;

    cnt_t    cnt_reg,    cnt_next;
    addr_t   idx_reg,    idx_next;
    cnt_t    scan_reg,   scan_next;
    data_t   val_reg,    val_next;
    status_t status_reg, status_next;
    logic    found_reg,  found_next;
    data_t   root_reg,   root_next;

    logic    rsp_valid_reg,     rsp_valid_next;
    status_t rsp_status_reg,    rsp_status_next;
    cnt_t    rsp_total_reg,     rsp_total_next;
    logic    rsp_top_valid_reg, rsp_top_valid_next;
    data_t   rsp_top_value_reg, rsp_top_value_next;

    addr_t                parent_idx;
    cnt_t                 left_idx;
    logic [CNT_W:0]       right_idx;
    cnt_t                 cnt_dec;
    cnt_t                 scan_dec;
    logic                 scan_hit;
    logic                 scan_end;
    logic                 pick_right;
    addr_t                big_idx;
    data_t                big_val;

    mhi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign cmd.ready         = ctrl.cmd_ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_total = rsp_total_reg;
    assign rsp.top_valid     = rsp_top_valid_reg;
    assign rsp.top_value     = rsp_top_value_reg;

    // heap index arithmetic
    always_comb
    begin
        parent_idx = (idx_reg - addr_t'(1)) >> 1;
        left_idx   = {idx_reg, 1'b1};
        right_idx  = {({1'b0, idx_reg} + cnt_t'(1)), 1'b0};
        cnt_dec    = cnt_reg - cnt_t'(1);
        scan_dec   = scan_reg - cnt_t'(1);
        scan_hit   = (rd_a_reg == val_reg);
        scan_end   = (scan_reg == cnt_reg);
        pick_right = (right_idx < {1'b0, cnt_reg}) && key_gt(rd_b_reg, rd_a_reg);
        big_idx    = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        big_val    = pick_right ? rd_b_reg : rd_a_reg;
    end

    always_comb
    begin
        flags.op_del    = (cmd.operation == OP_DELETE);
        flags.full      = (cnt_reg == cnt_t'(CAPACITY));
        flags.idx_zero  = (idx_reg == '0);
        flags.up_gt     = key_gt(val_reg, rd_a_reg);
        flags.empty     = (cnt_reg == '0);
        flags.scan_stop = scan_hit || scan_end;
        flags.del_end   = !found_reg || ({1'b0, idx_reg} == cnt_dec);
        flags.sift_up   = (idx_reg != '0) && key_gt(val_reg, rd_a_reg);
        flags.no_left   = (left_idx >= cnt_reg);
        flags.dn_gt     = key_gt(big_val, val_reg);
        flags.cmd_valid = cmd.valid;
        flags.rsp_free  = !rsp_valid_reg || rsp.ready;
    end

    // datapath decode
    always_comb
    begin
        cnt_next           = cnt_reg;
        idx_next           = idx_reg;
        scan_next          = scan_reg;
        val_next           = val_reg;
        status_next        = status_reg;
        found_next         = found_reg;
        root_next          = root_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp.ready;
        rsp_status_next    = rsp_status_reg;
        rsp_total_next     = rsp_total_reg;
        rsp_top_valid_next = rsp_top_valid_reg;
        rsp_top_value_next = rsp_top_value_reg;
        rd_a_addr          = idx_reg;
        rd_b_addr          = right_idx[ADDR_W-1:0];
        mem_we             = 1'b0;
        mem_waddr          = idx_reg;
        mem_wdata          = val_reg;

        if (ctrl.go)
        begin
            unique case (ctrl.act)
                ACT_NOP:
                begin
                end
                ACT_LOAD:
                begin
                    val_next    = cmd.value;
                    status_next = STS_DONE;
                    found_next  = 1'b0;
                end
                ACT_INS:
                begin
                    if (flags.full)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        idx_next = cnt_reg[ADDR_W-1:0];
                        cnt_next = cnt_reg + cnt_t'(1);
                    end
                end
                ACT_UP_RD, ACT_MOVE:
                begin
                    rd_a_addr = parent_idx;
                    if (ctrl.act == ACT_MOVE)
                    begin
                        val_next = rd_a_reg;
                    end
                end
                ACT_UP_MV:
                begin
                    // pull the parent down into the hole
                    if (flags.up_gt)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_a_reg;
                        idx_next  = parent_idx;
                    end
                end
                ACT_PUT:
                begin
                    mem_we = 1'b1;
                end
                ACT_FIN:
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_status_next    = status_reg;
                    rsp_total_next     = cnt_reg;
                    rsp_top_valid_next = (cnt_reg != '0);
                    rsp_top_value_next = (cnt_reg != '0) ? root_reg : '0;
                end
                ACT_DEL_START:
                begin
                    if (flags.empty)
                    begin
                        status_next = STS_EMPTY;
                    end
                    rd_a_addr = '0;
                    scan_next = cnt_t'(1);
                end
                ACT_SCAN:
                begin
                    // data in rd_a_reg belongs to entry scan-1
                    rd_a_addr = scan_reg[ADDR_W-1:0];
                    if (scan_hit)
                    begin
                        found_next = 1'b1;
                        idx_next   = scan_dec[ADDR_W-1:0];
                    end
                    else if (scan_end)
                    begin
                        status_next = STS_NOT_FOUND;
                    end
                    else
                    begin
                        scan_next = scan_reg + cnt_t'(1);
                    end
                end
                ACT_SHRINK:
                begin
                    rd_a_addr = cnt_dec[ADDR_W-1:0];
                    if (found_reg)
                    begin
                        cnt_next = cnt_dec;
                    end
                end
                ACT_DN_RD:
                begin
                    rd_a_addr = left_idx[ADDR_W-1:0];
                end
                ACT_DN_MV:
                begin
                    // lift the larger child into the hole
                    if (flags.dn_gt)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = big_val;
                        idx_next  = big_idx;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (mem_we && (mem_waddr == '0))
        begin
            root_next = mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        scan_reg          <= scan_next;
        val_reg           <= val_next;
        status_reg        <= status_next;
        root_reg          <= root_next;
        rsp_status_reg    <= rsp_status_next;
        rsp_total_reg     <= rsp_total_next;
        rsp_top_valid_reg <= rsp_top_valid_next;
        rsp_top_value_reg <= rsp_top_value_next;
    end

    // heap store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem_reg[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= heap_mem_reg[rd_a_addr];
        rd_b_reg <= heap_mem_reg[rd_b_addr];
    end

endmodule
`default_nettype wire

>>> src/mhi_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mhi_seq: microcode sequencer of the heap unit
// Step counter, control ROM lookup and two-way conditional branch.
// ---------------------------------------------------------------------------
module mhi_seq
    import mhi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   taken;
    logic   go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        word = ucode_rom(step_reg);

        unique case (word.cond)
            CND_ALWAYS:    taken = 1'b1;
            CND_OP_DEL:    taken = flags.op_del;
            CND_FULL:      taken = flags.full;
            CND_IDX_ZERO:  taken = flags.idx_zero;
            CND_UP_GT:     taken = flags.up_gt;
            CND_EMPTY:     taken = flags.empty;
            CND_SCAN_STOP: taken = flags.scan_stop;
            CND_DEL_END:   taken = flags.del_end;
            CND_SIFT_UP:   taken = flags.sift_up;
            CND_NO_LEFT:   taken = flags.no_left;
            CND_DN_GT:     taken = flags.dn_gt;
            default:       taken = 1'b0;
        endcase

        // hold the step while waiting on either channel
        go = !(word.wait_cmd && !flags.cmd_valid) && !(word.wait_rsp && !flags.rsp_free);

        if (!go)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = word.t_step;
        end
        else
        begin
            step_next = word.f_step;
        end

        ctrl.act       = word.act;
        ctrl.go        = go;
        ctrl.cmd_ready = word.wait_cmd;
    end

endmodule
`default_nettype wire
